// ----- sv/sv39ptm_pkg.sv -----
// ---------------------------------------------------------------------------
// sv39ptm_pkg: shared definitions for the Sv39 page table map engine
// Sizes of the table store, entry layout, operation and status codes.
// ---------------------------------------------------------------------------
package sv39ptm_pkg;

   // table store geometry
   localparam int TABLE_PAGES      = 16;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int MAX_RUN_PAGES    = 64;
   localparam int VPN_LIMIT        = 67108864;

   localparam int IDX_BITS    = $clog2(ENTRIES_PER_PAGE);
   localparam int PAGE_BITS   = $clog2(TABLE_PAGES);
   localparam int NFP_BITS    = PAGE_BITS + 1;
   localparam int STORE_DEPTH = TABLE_PAGES * ENTRIES_PER_PAGE;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);

   // field widths
   localparam int ENTRY_BITS = 54;
   localparam int FRAME_BITS = 44;
   localparam int VPN_BITS   = 27;
   localparam int COUNT_BITS = 7;
   localparam int PERM_BITS  = 8;

   typedef logic [ENTRY_BITS-1:0] entry_type;
   typedef logic [FRAME_BITS-1:0] frame_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [PAGE_BITS-1:0]  page_type;

   // valid flag of an entry
   localparam logic [PERM_BITS-1:0] PTE_V = 8'h01;

   // operation codes
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_MAP    = 2'd1;
   localparam logic [1:0] OP_UNMAP  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   // status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_UNMAPPED = 3'd1;
   localparam logic [2:0] STAT_RANGE    = 3'd2;
   localparam logic [2:0] STAT_NOPAGE   = 3'd3;
   localparam logic [2:0] STAT_REMAP    = 3'd4;
   localparam logic [2:0] STAT_BADPTR   = 3'd5;

endpackage

// ----- sv/sv39ptm_ram.sv -----
// ---------------------------------------------------------------------------
// sv39ptm_ram: generic simple dual-port RAM
// One write port and one read port; read data registered.
// ---------------------------------------------------------------------------
module sv39ptm_ram #(
   parameter int WIDTH = 54,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sv39_page_table_map_engine.sv -----
// ---------------------------------------------------------------------------
// sv39_page_table_map_engine: Sv39 page table lookup / map / unmap engine
// Walks a three-level table kept in one on-chip store and gives one result
// item per page of a run.
// ---------------------------------------------------------------------------
// Each page goes through PAGE, then a read and an evaluate at each of the
// three levels through the single store read port; a page out of range ends
// in PAGE, a failed walk ends sooner. A map that takes a new table first clears
// that page of the store, then writes the pointer to it. One item at a time:
// busy stays high until the last result item strobes; results cannot stall.
// Reset (synchronous) starts a clearing pass over all 8192 store entries with
// busy high; csr writes are taken during it.
// ---------------------------------------------------------------------------
module sv39_page_table_map_engine (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_enable,
   input  logic [43:0] csr_write_data,
   // command
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [26:0] req_page_number,
   input  logic [43:0] req_frame_number,
   input  logic [6:0]  req_page_count,
   input  logic [7:0]  req_permission_bits,
   input  logic        req_free_frames,
   // results
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [53:0] rsp_entry_value,
   output logic [43:0] rsp_freed_frame,
   output logic        rsp_freed_valid,
   output logic        rsp_last_result
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_PAGE  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;
   localparam logic [2:0] S_PTRW  = 3'd5;

   localparam int VB = sv39ptm_pkg::VPN_BITS + 1;
   localparam int IB = sv39ptm_pkg::IDX_BITS;
   localparam int PB = sv39ptm_pkg::PAGE_BITS;
   localparam int NB = sv39ptm_pkg::NFP_BITS;
   localparam int CB = sv39ptm_pkg::COUNT_BITS;

   // control state
   logic [2:0]                 state_ff, state_in;
   logic [2:0]                 clr_ret_ff, clr_ret_in;
   sv39ptm_pkg::addr_type      clr_addr_ff, clr_addr_in;
   sv39ptm_pkg::addr_type      clr_end_ff, clr_end_in;
   logic [NB-1:0]              nfp_ff, nfp_in;
   sv39ptm_pkg::frame_type     base_ff, base_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // item context
   logic [1:0]                 op_ff, op_in;
   logic [VB-1:0]              vpn_ff, vpn_in;
   sv39ptm_pkg::frame_type     frame_ff, frame_in;
   logic [CB-1:0]              rem_ff, rem_in;
   logic [7:0]                 perm_ff, perm_in;
   logic                       release_ff, release_in;
   sv39ptm_pkg::page_type      page_ff, page_in;
   logic [1:0]                 level_ff, level_in;
   sv39ptm_pkg::addr_type      slot_ff, slot_in;

   // result registers
   logic [2:0]                 rsp_status_ff, rsp_status_in;
   sv39ptm_pkg::entry_type     rsp_entry_ff, rsp_entry_in;
   sv39ptm_pkg::frame_type     rsp_freed_ff, rsp_freed_in;
   logic                       rsp_fvalid_ff, rsp_fvalid_in;
   logic                       rsp_last_ff, rsp_last_in;

   // store port signals
   logic                       wr_en;
   sv39ptm_pkg::addr_type      wr_addr;
   sv39ptm_pkg::entry_type     wr_data;
   logic                       rd_en;
   sv39ptm_pkg::addr_type      rd_addr;
   sv39ptm_pkg::entry_type     rd_data;

   // walk helpers
   logic [IB-1:0]              idx_sel;
   sv39ptm_pkg::frame_type     ptr_off;
   sv39ptm_pkg::frame_type     old_frame;
   logic                       old_valid;
   logic                       emit;
   logic [2:0]                 emit_status;
   sv39ptm_pkg::entry_type     emit_entry;
   sv39ptm_pkg::frame_type     emit_freed;
   logic                       emit_fvalid;

   sv39ptm_ram #(
      .WIDTH(sv39ptm_pkg::ENTRY_BITS),
      .DEPTH(sv39ptm_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // table index of the current level
   always_comb begin
      case (level_ff)
         2'd2:    idx_sel = vpn_ff[3*IB-1:2*IB];
         2'd1:    idx_sel = vpn_ff[2*IB-1:IB];
         default: idx_sel = vpn_ff[IB-1:0];
      endcase
   end

   assign ptr_off   = rd_data[sv39ptm_pkg::ENTRY_BITS-1:10] - base_ff;
   assign old_frame = rd_data[sv39ptm_pkg::ENTRY_BITS-1:10];
   assign old_valid = (rd_data[7:0] & sv39ptm_pkg::PTE_V) != 8'd0;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_ret_in    = clr_ret_ff;
      clr_addr_in   = clr_addr_ff;
      clr_end_in    = clr_end_ff;
      nfp_in        = nfp_ff;
      base_in       = csr_write_enable ? csr_write_data : base_ff;
      rsp_valid_in  = 1'b0;
      op_in         = op_ff;
      vpn_in        = vpn_ff;
      frame_in      = frame_ff;
      rem_in        = rem_ff;
      perm_in       = perm_ff;
      release_in    = release_ff;
      page_in       = page_ff;
      level_in      = level_ff;
      slot_in       = slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_fvalid_in = rsp_fvalid_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = {page_ff, idx_sel};
      emit          = 1'b0;
      emit_status   = sv39ptm_pkg::STAT_OK;
      emit_entry    = '0;
      emit_freed    = '0;
      emit_fvalid   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req_operation;
               vpn_in     = {1'b0, req_page_number};
               frame_in   = req_frame_number;
               perm_in    = req_permission_bits;
               release_in = req_free_frames;
               if (req_operation == sv39ptm_pkg::OP_LOOKUP) begin
                  rem_in = CB'(1);
               end else if (req_page_count > CB'(sv39ptm_pkg::MAX_RUN_PAGES)) begin
                  rem_in = CB'(sv39ptm_pkg::MAX_RUN_PAGES);
               end else begin
                  rem_in = req_page_count;
               end
               if (req_operation != sv39ptm_pkg::OP_NONE &&
                   !(req_operation != sv39ptm_pkg::OP_LOOKUP && req_page_count == '0)) begin
                  state_in = S_PAGE;
               end
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            if (clr_addr_ff == clr_end_ff) begin
               state_in = clr_ret_ff;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_PAGE: begin
            if (vpn_ff >= VB'(sv39ptm_pkg::VPN_LIMIT)) begin
               emit        = 1'b1;
               emit_status = sv39ptm_pkg::STAT_RANGE;
            end else begin
               level_in = 2'd2;
               page_in  = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            rd_en    = 1'b1;
            rd_addr  = {page_ff, idx_sel};
            slot_in  = {page_ff, idx_sel};
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (level_ff != 2'd0) begin
               // pointer level
               if (old_valid) begin
                  if (ptr_off >= sv39ptm_pkg::FRAME_BITS'(sv39ptm_pkg::TABLE_PAGES)) begin
                     emit        = 1'b1;
                     emit_status = sv39ptm_pkg::STAT_BADPTR;
                  end else begin
                     page_in  = ptr_off[PB-1:0];
                     level_in = level_ff - 2'd1;
                     state_in = S_READ;
                  end
               end else if (op_ff != sv39ptm_pkg::OP_MAP) begin
                  emit        = 1'b1;
                  emit_status = sv39ptm_pkg::STAT_UNMAPPED;
               end else if (nfp_ff >= NB'(sv39ptm_pkg::TABLE_PAGES)) begin
                  emit        = 1'b1;
                  emit_status = sv39ptm_pkg::STAT_NOPAGE;
               end else begin
                  // take a fresh table: clear it, then link it
                  page_in     = nfp_ff[PB-1:0];
                  nfp_in      = nfp_ff + 1'b1;
                  level_in    = level_ff - 2'd1;
                  clr_addr_in = {nfp_ff[PB-1:0], {IB{1'b0}}};
                  clr_end_in  = {nfp_ff[PB-1:0], {IB{1'b1}}};
                  clr_ret_in  = S_PTRW;
                  state_in    = S_CLEAR;
               end
            end else begin
               // leaf level
               emit = 1'b1;
               case (op_ff)
                  sv39ptm_pkg::OP_LOOKUP: begin
                     emit_entry  = rd_data;
                     emit_status = old_valid ? sv39ptm_pkg::STAT_OK
                                             : sv39ptm_pkg::STAT_UNMAPPED;
                  end
                  sv39ptm_pkg::OP_MAP: begin
                     if (old_valid && old_frame != frame_ff) begin
                        emit_status = sv39ptm_pkg::STAT_REMAP;
                        emit_entry  = rd_data;
                     end else begin
                        emit_entry = {frame_ff, 2'b00, perm_ff | sv39ptm_pkg::PTE_V};
                        wr_en      = 1'b1;
                        wr_addr    = slot_ff;
                        wr_data    = {frame_ff, 2'b00, perm_ff | sv39ptm_pkg::PTE_V};
                     end
                  end
                  default: begin
                     if (old_valid) begin
                        emit_entry  = rd_data;
                        emit_freed  = release_ff ? old_frame : '0;
                        emit_fvalid = release_ff;
                        wr_en       = 1'b1;
                        wr_addr     = slot_ff;
                        wr_data     = '0;
                     end else begin
                        emit_status = sv39ptm_pkg::STAT_UNMAPPED;
                     end
                  end
               endcase
            end
         end
         S_PTRW: begin
            wr_en    = 1'b1;
            wr_addr  = slot_ff;
            wr_data  = {base_ff + sv39ptm_pkg::FRAME_BITS'(page_ff), 9'd0, 1'b1};
            state_in = S_READ;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // deliver one result item and step to the next page of the run
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_entry_in  = emit_entry;
         rsp_freed_in  = emit_freed;
         rsp_fvalid_in = emit_fvalid;
         rsp_last_in   = (rem_ff == CB'(1));
         if (rem_ff == CB'(1)) begin
            state_in = S_IDLE;
         end else begin
            state_in = S_PAGE;
            vpn_in   = vpn_ff + 1'b1;
            frame_in = frame_ff + 1'b1;
            rem_in   = rem_ff - 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ret_ff   <= S_IDLE;
         clr_addr_ff  <= '0;
         clr_end_ff   <= sv39ptm_pkg::ADDR_BITS'(sv39ptm_pkg::STORE_DEPTH - 1);
         nfp_ff       <= NB'(1);
         base_ff      <= csr_write_enable ? csr_write_data : '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ret_ff   <= clr_ret_in;
         clr_addr_ff  <= clr_addr_in;
         clr_end_ff   <= clr_end_in;
         nfp_ff       <= nfp_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      vpn_ff        <= vpn_in;
      frame_ff      <= frame_in;
      rem_ff        <= rem_in;
      perm_ff       <= perm_in;
      release_ff    <= release_in;
      page_ff       <= page_in;
      level_ff      <= level_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_fvalid_ff <= rsp_fvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_entry_ff;
   assign rsp_freed_frame = rsp_freed_ff;
   assign rsp_freed_valid = rsp_fvalid_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

// ----- tb/sv/sv39_page_table_map_engine_tb.sv -----
// ---------------------------------------------------------------------------
// sv39_page_table_map_engine_tb: self-checking bench for the Sv39 map engine
// Drives lookup, map and unmap items over the start/busy handshake, keeps a
// shadow copy of the table store and the page allocator, and checks every
// result item in order. A short directed table comes first, followed by
// random phases under different table base frames.
// ---------------------------------------------------------------------------
module sv39_page_table_map_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                     CYCLE_LIMIT = 1000000;
   localparam int                     SETTLE_CYCLES = 16;
   localparam int                     END_PAUSE = 64;
   localparam sv39ptm_pkg::frame_type FRAME_MAX = '1;

   // one command item
   typedef struct packed {
      logic [1:0]                         op;
      logic [sv39ptm_pkg::VPN_BITS-1:0]   vpn;
      sv39ptm_pkg::frame_type             frame;
      logic [sv39ptm_pkg::COUNT_BITS-1:0] count;
      logic [sv39ptm_pkg::PERM_BITS-1:0]  perm;
      logic                               free;
   } map_request_type;

   // one result item, one per page
   typedef struct packed {
      logic [2:0]             status;
      sv39ptm_pkg::entry_type entry;
      sv39ptm_pkg::frame_type freed;
      logic                   freed_valid;
      logic                   last;
   } page_result_type;

   // directed row: item plus an optional hand-written result
   typedef struct packed {
      map_request_type        req;
      logic                   typed;
      logic [2:0]             status;
      sv39ptm_pkg::entry_type entry;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [43:0] csr_write_data = '0;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = '0;
   logic [26:0] req_page_number = '0;
   logic [43:0] req_frame_number = '0;
   logic [6:0]  req_page_count = '0;
   logic [7:0]  req_permission_bits = '0;
   logic        req_free_frames = 1'b0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [53:0] rsp_entry_value;
   logic [43:0] rsp_freed_frame;
   logic        rsp_freed_valid;
   logic        rsp_last_result;

   // shadow state of the engine
   sv39ptm_pkg::entry_type pt_store [sv39ptm_pkg::STORE_DEPTH] = '{default: '0};
   int unsigned            next_table_page = 1;
   sv39ptm_pkg::frame_type table_base = '0;
   page_result_type        expected_pages [$];

   int unsigned mismatch_count = 0;
   int unsigned quiet_run = 0;
   int unsigned cycle_count;

   // directed items, base frame is all ones while they run
   stim_row_type stim_rows [21] = '{
      '{'{sv39ptm_pkg::OP_LOOKUP, 27'h0, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_UNMAPPED, 54'h0},
      '{'{sv39ptm_pkg::OP_MAP, 27'h0, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_OK, 54'h1},
      '{'{sv39ptm_pkg::OP_LOOKUP, 27'h0, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_OK, 54'h1},
      '{'{sv39ptm_pkg::OP_MAP, 27'h0, FRAME_MAX, 7'd1, 8'hFF, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_REMAP, 54'h1},
      '{'{sv39ptm_pkg::OP_MAP, 27'h0, 44'h0, 7'd1, 8'hFE, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_OK, 54'hFF},
      '{'{sv39ptm_pkg::OP_MAP, 27'h1, FRAME_MAX, 7'd1, 8'hFF, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_OK, 54'h3F_FFFF_FFFF_FCFF},
      '{'{sv39ptm_pkg::OP_LOOKUP, 27'h1, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_OK, 54'h3F_FFFF_FFFF_FCFF},
      '{'{sv39ptm_pkg::OP_UNMAP, 27'h1, 44'h0, 7'd1, 8'h00, 1'b1}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0},
      '{'{sv39ptm_pkg::OP_UNMAP, 27'h1, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_UNMAPPED, 54'h0},
      '{'{sv39ptm_pkg::OP_LOOKUP, 27'h400_0000, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_RANGE, 54'h0},
      '{'{sv39ptm_pkg::OP_LOOKUP, 27'h7FF_FFFF, FRAME_MAX, 7'd127, 8'hFF, 1'b1}, 1'b1,
        sv39ptm_pkg::STAT_RANGE, 54'h0},
      '{'{sv39ptm_pkg::OP_MAP, 27'h3FF_FFFE, 44'd100, 7'd4, 8'hC6, 1'b1}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0},
      '{'{sv39ptm_pkg::OP_MAP, 27'h20, 44'h5, 7'd0, 8'h11, 1'b0}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0},
      '{'{sv39ptm_pkg::OP_NONE, 27'h5, 44'h7, 7'd9, 8'h0F, 1'b1}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0},
      '{'{sv39ptm_pkg::OP_MAP, 27'h1FE, 44'hFFF_FFFF_FFFD, 7'd127, 8'h3C, 1'b0}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0},
      '{'{sv39ptm_pkg::OP_UNMAP, 27'h1FE, 44'h0, 7'd64, 8'h00, 1'b1}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0},
      '{'{sv39ptm_pkg::OP_LOOKUP, 27'h0, 44'h0, 7'd0, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_OK, 54'hFF},
      '{'{sv39ptm_pkg::OP_UNMAP, 27'h0, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b1,
        sv39ptm_pkg::STAT_OK, 54'hFF},
      '{'{sv39ptm_pkg::OP_UNMAP, 27'h1_0000, 44'h0, 7'd1, 8'h00, 1'b1}, 1'b1,
        sv39ptm_pkg::STAT_UNMAPPED, 54'h0},
      '{'{sv39ptm_pkg::OP_LOOKUP, 27'h3FF_FFFF, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0},
      '{'{sv39ptm_pkg::OP_MAP, 27'h3FF_FFFF, 44'h0, 7'd1, 8'h00, 1'b0}, 1'b0,
        sv39ptm_pkg::STAT_OK, 54'h0}
   };

   // random items per phase; the base frame changes between phases
   int unsigned phase_items [4] = '{180, 50, 40, 100};

   sv39_page_table_map_engine DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_page_number     (req_page_number),
      .req_frame_number    (req_frame_number),
      .req_page_count      (req_page_count),
      .req_permission_bits (req_permission_bits),
      .req_free_frames     (req_free_frames),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_entry_value     (rsp_entry_value),
      .rsp_freed_frame     (rsp_freed_frame),
      .rsp_freed_valid     (rsp_freed_valid),
      .rsp_last_result     (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // walk root and middle tables to the leaf slot, growing them for a map
   function automatic logic [2:0] walk_to_leaf(
      input logic [sv39ptm_pkg::VPN_BITS-1:0] vpn,
      input bit grow, output sv39ptm_pkg::addr_type leaf);
      int unsigned            page;
      int unsigned            slot;
      int                     level;
      int                     k;
      logic [8:0]             idx;
      sv39ptm_pkg::entry_type pte;
      sv39ptm_pkg::frame_type off;
      page = 0;
      leaf = '0;
      for (level = 2; level > 0; level--) begin
         idx  = (level == 2) ? vpn[26:18] : vpn[17:9];
         slot = page * sv39ptm_pkg::ENTRIES_PER_PAGE + idx;
         pte  = pt_store[slot];
         if (pte[0]) begin
            // pointer must land inside the store under the current base
            off = pte[53:10] - table_base;
            if (off >= sv39ptm_pkg::TABLE_PAGES) return sv39ptm_pkg::STAT_BADPTR;
            page = 32'(off);
         end else begin
            if (!grow) return sv39ptm_pkg::STAT_UNMAPPED;
            if (next_table_page >= sv39ptm_pkg::TABLE_PAGES) return sv39ptm_pkg::STAT_NOPAGE;
            page = next_table_page;
            next_table_page++;
            for (k = 0; k < sv39ptm_pkg::ENTRIES_PER_PAGE; k++)
               pt_store[page * sv39ptm_pkg::ENTRIES_PER_PAGE + k] = '0;
            pt_store[slot] = {sv39ptm_pkg::frame_type'(table_base + page), 10'h001};
         end
      end
      leaf = sv39ptm_pkg::addr_type'(page * sv39ptm_pkg::ENTRIES_PER_PAGE + vpn[8:0]);
      return sv39ptm_pkg::STAT_OK;
   endfunction

   // expected result items of one accepted item, state updated as we go
   function automatic void predict_pages(input map_request_type r);
      int unsigned            run_len;
      int unsigned            i;
      logic [27:0]            vpn;
      sv39ptm_pkg::frame_type pa;
      sv39ptm_pkg::addr_type  leaf;
      sv39ptm_pkg::entry_type old;
      page_result_type        res;
      if (r.op == sv39ptm_pkg::OP_NONE) return;
      if (r.op == sv39ptm_pkg::OP_LOOKUP) run_len = 1;
      else if (r.count == 0) return;
      else run_len = (r.count > sv39ptm_pkg::MAX_RUN_PAGES) ? sv39ptm_pkg::MAX_RUN_PAGES
                                                            : r.count;
      for (i = 0; i < run_len; i++) begin
         vpn = 28'(r.vpn + i);
         pa = sv39ptm_pkg::frame_type'(r.frame + i);
         res = '0;
         res.last = (i + 1 == run_len);
         if (vpn >= sv39ptm_pkg::VPN_LIMIT) begin
            res.status = sv39ptm_pkg::STAT_RANGE;
         end else begin
            res.status = walk_to_leaf(vpn[26:0], r.op == sv39ptm_pkg::OP_MAP, leaf);
            if (res.status == sv39ptm_pkg::STAT_OK) begin
               old = pt_store[leaf];
               case (r.op)
                  sv39ptm_pkg::OP_LOOKUP: begin
                     res.entry = old;
                     if (!old[0]) res.status = sv39ptm_pkg::STAT_UNMAPPED;
                  end
                  sv39ptm_pkg::OP_MAP: begin
                     // same frame rewrites the flags, another frame conflicts
                     if (old[0] && old[53:10] != pa) begin
                        res.status = sv39ptm_pkg::STAT_REMAP;
                        res.entry  = old;
                     end else begin
                        res.entry = {pa, 2'b00, r.perm | sv39ptm_pkg::PTE_V};
                        pt_store[leaf] = res.entry;
                     end
                  end
                  default: begin
                     if (old[0]) begin
                        res.entry = old;
                        if (r.free) begin
                           res.freed       = old[53:10];
                           res.freed_valid = 1'b1;
                        end
                        pt_store[leaf] = '0;
                     end else begin
                        res.status = sv39ptm_pkg::STAT_UNMAPPED;
                     end
                  end
               endcase
            end
         end
         expected_pages.push_back(res);
      end
   endfunction

   // idle gap before an item: mostly short, some long, bursts with none
   function automatic int unsigned pick_gap();
      int unsigned p;
      if (quiet_run != 0) begin
         quiet_run--;
         return 0;
      end
      p = $urandom_range(0, 99);
      if (p < 4) begin
         quiet_run = $urandom_range(10, 30);
         return 0;
      end
      if (p < 40) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // random item, mostly aimed at a few table regions so walks go deep
   function automatic map_request_type random_request();
      map_request_type r;
      int unsigned     p;
      logic [8:0]      root_idx;
      logic [8:0]      mid_idx;
      p = $urandom_range(0, 99);
      if (p < 30) r.op = sv39ptm_pkg::OP_LOOKUP;
      else if (p < 68) r.op = sv39ptm_pkg::OP_MAP;
      else if (p < 96) r.op = sv39ptm_pkg::OP_UNMAP;
      else r.op = sv39ptm_pkg::OP_NONE;

      case ($urandom_range(0, 2))
         0: root_idx = 9'd0;
         1: root_idx = 9'd1;
         default: root_idx = 9'd255;
      endcase
      case ($urandom_range(0, 2))
         0: mid_idx = 9'd0;
         1: mid_idx = 9'd1;
         default: mid_idx = 9'd511;
      endcase
      p = $urandom_range(0, 99);
      if (p < 84) r.vpn = {root_idx, mid_idx, 9'($urandom_range(0, 511))};
      else if (p < 91) r.vpn = 27'($urandom_range(0, sv39ptm_pkg::VPN_LIMIT - 1));
      else if (p < 96) r.vpn = 27'(sv39ptm_pkg::VPN_LIMIT - $urandom_range(1, 70));
      else r.vpn = 27'($urandom);

      // frame tied to the page number makes repeated maps hit the same frame
      p = $urandom_range(0, 99);
      if (p < 50) r.frame = sv39ptm_pkg::frame_type'(r.vpn);
      else if (p < 60) r.frame = FRAME_MAX - sv39ptm_pkg::frame_type'($urandom_range(0, 63));
      else r.frame = sv39ptm_pkg::frame_type'({$urandom, $urandom});

      p = $urandom_range(0, 99);
      if (r.op == sv39ptm_pkg::OP_LOOKUP) r.count = 7'($urandom_range(0, 127));
      else if (p < 4) r.count = '0;
      else if (p < 80) r.count = 7'($urandom_range(1, 6));
      else if (p < 95) r.count = 7'($urandom_range(7, 64));
      else r.count = 7'($urandom_range(65, 127));

      r.perm = 8'($urandom_range(0, 255));
      r.free = 1'($urandom_range(0, 1));
      return r;
   endfunction

   // present one item and wait for the edge that takes it
   task automatic send_request(input map_request_type r);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_operation       <= r.op;
      req_page_number     <= r.vpn;
      req_frame_number    <= r.frame;
      req_page_count      <= r.count;
      req_permission_bits <= r.perm;
      req_free_frames     <= r.free;
      do @(posedge clock); while (busy);
      predict_pages(r);
   endtask

   // engine idle: all results in, trailing no-result items done
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_pages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_table_base(input sv39ptm_pkg::frame_type value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      table_base = value;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] want_v,
                                  input logic [63:0] got_v);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
      mismatch_count++;
   endtask

   // result checker, one item per strobe
   always @(posedge clock) begin : check_results
      page_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_pages.size() == 0) begin
            $display("%0t: unexpected result item, expected none, actual status %0d entry %h",
                     $time, rsp_status, rsp_entry_value);
            mismatch_count++;
         end else begin
            want = expected_pages.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", 64'(want.status),
                                                            64'(rsp_status));
            if (rsp_entry_value !== want.entry) report_mismatch("entry_value", 64'(want.entry),
                                                                64'(rsp_entry_value));
            if (rsp_freed_frame !== want.freed) report_mismatch("freed_frame", 64'(want.freed),
                                                                64'(rsp_freed_frame));
            if (rsp_freed_valid !== want.freed_valid)
               report_mismatch("freed_valid", 64'(want.freed_valid), 64'(rsp_freed_valid));
            if (rsp_last_result !== want.last) report_mismatch("last_result", 64'(want.last),
                                                               64'(rsp_last_result));
         end
      end
   end

   initial begin : watchdog
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("timeout after %0d cycles, %0d result items outstanding", cycle_count,
               expected_pages.size());
      $display("sv39_page_table_map_engine regression: fail");
      $finish;
   end

   initial begin : stimulus
      map_request_type        req;
      page_result_type        typed_res;
      sv39ptm_pkg::frame_type base_value;
      int                     row;
      int                     phase;
      int unsigned            sent;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-ones base: pointer frames wrap around zero
      write_table_base(FRAME_MAX);

      // directed table
      for (row = 0; row < $size(stim_rows); row++) begin
         send_request(stim_rows[row].req);
         if (stim_rows[row].typed) begin
            typed_res = '0;
            typed_res.status = stim_rows[row].status;
            typed_res.entry  = stim_rows[row].entry;
            typed_res.last   = 1'b1;
            void'(expected_pages.pop_back());
            expected_pages.push_back(typed_res);
         end
      end

      // random phases; a new base turns the old pointers into bad ones
      for (phase = 0; phase < 4; phase++) begin
         if (phase > 0) begin
            wait_idle();
            case (phase)
               1: base_value = '0;
               2: base_value = sv39ptm_pkg::frame_type'({$urandom, $urandom});
               default: base_value = FRAME_MAX;
            endcase
            write_table_base(base_value);
         end
         sent = 0;
         while (sent < phase_items[phase]) begin
            req = random_request();
            send_request(req);
            if (req.op != sv39ptm_pkg::OP_NONE &&
                (req.op == sv39ptm_pkg::OP_LOOKUP || req.count != 0)) sent++;
         end
      end

      start <= 1'b0;
      while (expected_pages.size() != 0) @(posedge clock);
      repeat (END_PAUSE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("sv39_page_table_map_engine regression: pass");
      end else begin
         $display("sv39_page_table_map_engine regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/sv39ptm_pkg.sv
sv/sv39ptm_ram.sv
sv/sv39_page_table_map_engine.sv
tb/sv/sv39_page_table_map_engine_tb.sv
